FILE: src/tidal_tensor_inverse_cube_top_macros.svh
// Assertion macros for the verification files of the tidal tensor block.
`ifndef TIDAL_TENSOR_INVERSE_CUBE_TOP_MACROS_SVH
`define TIDAL_TENSOR_INVERSE_CUBE_TOP_MACROS_SVH

// Checked only outside reset.
`define TT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/tt_pkg.sv
// Types and constants shared by the tidal tensor inverse-cube pipeline.
package tt_pkg;

  localparam int CW = 32;
  localparam int SW = 2 * CW;
  localparam int RW = CW;
  localparam int DW = 3 * CW;
  localparam int QW = 33;
  localparam int OW = 32;
  localparam logic [31:0] MASS_RESET = 32'h0001_0000;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
  } tt_in_t;

  typedef struct packed {
    logic signed [OW-1:0] radial_entry;
    logic signed [OW-1:0] transverse_entry;
    logic                 at_origin;
    logic                 saturated;
  } tt_out_t;

endpackage

FILE: src/tt_sumsq.sv
// Two-stage front end: coordinate magnitudes squared, then summed.
module tt_sumsq
  import tt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  tt_in_t        in_data,
  output logic          out_valid,
  output logic [SW-1:0] out_sum,
  output logic          out_orig
);

  logic [CW-1:0] mag_x, mag_y, mag_z;
  logic [SW-1:0] sqx_r, sqy_r, sqz_r;
  logic [SW-1:0] sum_r;
  logic [SW-1:0] sum_nxt;
  logic          v1_r, v2_r;

  assign mag_x = in_data.pos_x[CW-1] ? CW'(-in_data.pos_x) : CW'(in_data.pos_x);
  assign mag_y = in_data.pos_y[CW-1] ? CW'(-in_data.pos_y) : CW'(in_data.pos_y);
  assign mag_z = in_data.pos_z[CW-1] ? CW'(-in_data.pos_z) : CW'(in_data.pos_z);
  assign sum_nxt = sqx_r + sqy_r + sqz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= SW'(mag_x) * SW'(mag_x);
      sqy_r <= SW'(mag_y) * SW'(mag_y);
      sqz_r <= SW'(mag_z) * SW'(mag_z);
      sum_r <= sum_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_sum   = sum_r;
  assign out_orig  = (sum_r == '0);

endmodule

FILE: src/tt_isqrt.sv
// Integer square root, one result bit per pipeline stage.
module tt_isqrt
  import tt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [SW-1:0] in_sum,
  input  logic          in_orig,
  output logic          out_valid,
  output logic [RW-1:0] out_root,
  output logic          out_orig
);

  logic [SW-1:0] rem_r  [1:RW];
  logic [RW-1:0] root_r [1:RW];
  logic          org_r  [1:RW];
  logic          v_r    [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [SW-1:0] cur_rem;
    logic [RW-1:0] cur_root;
    logic          cur_org;
    logic          cur_v;
    logic [SW+1:0] trial;

    if (k == 0) begin : g_first
      assign cur_rem  = in_sum;
      assign cur_root = '0;
      assign cur_org  = in_orig;
      assign cur_v    = in_valid;
    end else begin : g_next
      assign cur_rem  = rem_r[k];
      assign cur_root = root_r[k];
      assign cur_org  = org_r[k];
      assign cur_v    = v_r[k];
    end

    assign trial = ((SW+2)'(cur_root) << (B + 1)) + ((SW+2)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        org_r[k+1] <= cur_org;
        if (trial <= (SW+2)'(cur_rem)) begin
          rem_r[k+1]  <= SW'((SW+2)'(cur_rem) - trial);
          root_r[k+1] <= cur_root | (RW'(1) << B);
        end else begin
          rem_r[k+1]  <= cur_rem;
          root_r[k+1] <= cur_root;
        end
      end
    end
  end

  assign out_valid = v_r[RW];
  assign out_root  = root_r[RW];
  assign out_orig  = org_r[RW];

endmodule

FILE: src/tt_cube.sv
// Three-stage cube of the radius with the wide product split into halves.
module tt_cube
  import tt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] in_root,
  input  logic          in_orig,
  output logic          out_valid,
  output logic [DW-1:0] out_cube,
  output logic          out_orig
);

  logic [2*RW-1:0] sq_r;
  logic [RW-1:0]   r1_r;
  logic [2*RW-1:0] plo_r, phi_r;
  logic [DW-1:0]   cube_r;
  logic [2:0]      v_r;
  logic [2:0]      org_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      org_r  <= {org_r[1:0], in_orig};
      sq_r   <= (2*RW)'(in_root) * (2*RW)'(in_root);
      r1_r   <= in_root;
      plo_r  <= (2*RW)'(sq_r[RW-1:0]) * (2*RW)'(r1_r);
      phi_r  <= (2*RW)'(sq_r[2*RW-1:RW]) * (2*RW)'(r1_r);
      cube_r <= (DW'(phi_r) << RW) + DW'(plo_r);
    end
  end

  assign out_valid = v_r[2];
  assign out_cube  = cube_r;
  assign out_orig  = org_r[2];

endmodule

FILE: src/tt_div.sv
// Restoring divider for mass over radius cubed, one quotient bit per stage,
// followed by the saturating output register.
module tt_div
  import tt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [31:0]   mass,
  input  logic          in_valid,
  input  logic [DW-1:0] in_cube,
  input  logic          in_orig,
  output logic          out_valid,
  output tt_out_t       out_data
);

  localparam int NW = 32 + 3 * FRAC_BITS;
  localparam int WW = (DW + QW + 1 > NW) ? DW + QW + 1 : NW + 1;

  logic [WW-1:0] num;
  logic [WW-1:0] rem_r [0:QW];
  logic [DW-1:0] d_r   [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic          ovf_r [0:QW];
  logic          org_r [0:QW];
  logic          v_r   [0:QW];
  tt_out_t       out_r;
  logic          vout_r;
  tt_out_t       out_nxt;
  logic          tsat, rsat;

  assign num = WW'(mass) << (3 * FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      d_r[0]   <= in_cube;
      q_r[0]   <= '0;
      ovf_r[0] <= ((WW'(in_cube) << QW) <= num);
      org_r[0] <= in_orig;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [WW-1:0] t;

    assign t = WW'(d_r[k]) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[k+1]   <= d_r[k];
        ovf_r[k+1] <= ovf_r[k];
        org_r[k+1] <= org_r[k];
        if (t <= rem_r[k]) begin
          rem_r[k+1] <= rem_r[k] - t;
          q_r[k+1]   <= q_r[k] | (QW'(1) << B);
        end else begin
          rem_r[k+1] <= rem_r[k];
          q_r[k+1]   <= q_r[k];
        end
      end
    end
  end

  always_comb begin
    tsat = ovf_r[QW] || (q_r[QW] > QW'(33'h0_7FFF_FFFF));
    rsat = ovf_r[QW] || (q_r[QW] > QW'(33'h0_4000_0000));
    out_nxt = '0;
    if (org_r[QW]) begin
      out_nxt.at_origin = 1'b1;
    end else begin
      out_nxt.transverse_entry = tsat ? 32'sh7FFF_FFFF : $signed(q_r[QW][31:0]);
      out_nxt.radial_entry     = rsat ? 32'sh8000_0000 : -$signed({q_r[QW][30:0], 1'b0});
      out_nxt.saturated        = tsat || rsat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (en) begin
      vout_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vout_r;
  assign out_data  = out_r;

endmodule

FILE: src/tidal_tensor_inverse_cube_top.sv
// Top level of the tidal tensor inverse-cube pipeline.
// Usage: each item on the in_ channel is a position (pos_x, pos_y, pos_z),
// signed Q16.16. For each item the out_ channel returns one item holding the
// radial entry -2*mass/r^3, the transverse entry mass/r^3, an at_origin flag
// and a saturated flag. The cfg_ channel writes the mass register; cfg_ready
// is always high, and the mass must only be changed while the pipeline holds
// no item.
// From acceptance to out_valid an item passes the squaring and summing
// stages, the square root stages (one bit per stage), the cube stages, the
// divider (an input stage and 33 quotient stages of one bit each) and the
// output register.
// Throughput is one item per cycle while out_stall does not hold the
// pipeline, set by the fully pipelined root and divider stages.
// Reset clears every valid bit and sets the mass to 1.0.
// When out_stall is high while a result is shown, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is lost or repeated.
module tidal_tensor_inverse_cube_top
  import tt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tt_in_t      in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output tt_out_t     out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic          en;
  logic [31:0]   mass_r;
  logic          s_valid, s_orig;
  logic [SW-1:0] s_sum;
  logic          r_valid, r_orig;
  logic [RW-1:0] r_root;
  logic          c_valid, c_orig;
  logic [DW-1:0] c_cube;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r <= MASS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mass_r <= cfg_data;
    end
  end

  tt_sumsq u_sumsq (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid), .in_data(in_data),
    .out_valid(s_valid), .out_sum(s_sum), .out_orig(s_orig)
  );

  tt_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s_valid), .in_sum(s_sum), .in_orig(s_orig),
    .out_valid(r_valid), .out_root(r_root), .out_orig(r_orig)
  );

  tt_cube u_cube (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(r_valid), .in_root(r_root), .in_orig(r_orig),
    .out_valid(c_valid), .out_cube(c_cube), .out_orig(c_orig)
  );

  tt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .mass(mass_r),
    .in_valid(c_valid), .in_cube(c_cube), .in_orig(c_orig),
    .out_valid(out_valid), .out_data(out_data)
  );

endmodule

FILE: src/tt_checker.sv
// Port-level checker for the tidal tensor pipeline and its bind statement.
`include "tidal_tensor_inverse_cube_top_macros.svh"

module tt_checker
  import tt_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    out_valid,
  input logic    out_stall,
  input tt_out_t out_data
);

  `TT_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled item changed")
  `TT_ASSERT(a_origin, out_valid && out_data.at_origin |-> out_data.radial_entry == 32'sd0 && out_data.transverse_entry == 32'sd0 && !out_data.saturated, "origin item not zero")
  `TT_ASSERT(a_ratio, out_valid && !out_data.saturated |-> 32'(out_data.radial_entry + out_data.transverse_entry + out_data.transverse_entry) == 32'd0, "radial is not minus twice transverse")
  `TT_ASSERT(a_sign, out_valid |-> !out_data.transverse_entry[31], "negative transverse entry")
  `TT_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_valid, "item shown after reset")

endmodule

bind tidal_tensor_inverse_cube_top tt_checker u_tt_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
